// ===== rtl/ludpp_pkg.sv =====
// Package for the LU decomposition block: sizes, sequencer states, saturation helper.
// No dependencies.
package ludpp_pkg;

  localparam int MAX_DIM = 8;
  localparam int IDX_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * IDX_W;
  localparam int DIM_W   = 4;
  localparam int TOL_W   = 31;
  localparam int DATA_W  = 32;
  localparam int CNT_W   = 3;

  // configuration register indexes
  localparam logic REG_TOLERANCE = 1'b0;
  localparam logic REG_SIZE      = 1'b1;

  typedef enum logic [4:0] {
    S_LOAD, S_PIV_RD, S_PIV_CMP, S_PIV_CHK,
    S_SW_RA, S_SW_RB, S_SW_WA, S_SW_WB,
    S_ROW_RD, S_ROW_CAP,
    S_F_RD, S_F_DIV, S_F_WAIT,
    S_E_RD, S_E_MUL, S_E_SAT, S_E_WR,
    S_O_RD, S_O_CAP, S_O_WAIT
  } state_t;

  // clamp a 48-bit signed value to 32-bit signed
  function automatic logic [31:0] sat48(input logic [47:0] v);
    logic [31:0] r;
    if (v[47] && !(&v[46:31]))       r = 32'h8000_0000;
    else if (!v[47] && (|v[46:31]))  r = 32'h7FFF_FFFF;
    else                             r = v[31:0];
    return r;
  endfunction

endpackage

// ===== rtl/ludpp_if.sv =====
// Stream interfaces for the LU decomposition block: element input and result output.
// Depends on ludpp_pkg.
interface ludpp_in_if import ludpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] element_value;
  modport source (output valid, output element_value, input ready);
  modport sink   (input valid, input element_value, output ready);
endinterface

interface ludpp_out_if import ludpp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              success;
  logic [IDX_W-1:0]  row_index;
  logic [IDX_W-1:0]  column_index;
  logic [DATA_W-1:0] lu_value;
  logic [IDX_W-1:0]  permutation_row;
  logic [CNT_W-1:0]  swap_count;
  logic              last_result;
  modport source (output valid, output success, output row_index, output column_index,
                  output lu_value, output permutation_row, output swap_count,
                  output last_result, input ready);
  modport sink   (input valid, input success, input row_index, input column_index,
                  input lu_value, input permutation_row, input swap_count,
                  input last_result, output ready);
endinterface

// ===== rtl/lu_decomposition_partial_pivot.sv =====
// Top level: LU decomposition with partial pivoting over one 64-entry matrix memory.
// Depends on ludpp_pkg, ludpp_in_if / ludpp_out_if, ludpp_div.
//
//  channel   dir  beat payload                                          handshake
//  in_ch     in   element_value (Q16.16, row-major)                     valid/ready
//  out_ch    out  success,row/column_index,lu_value,perm row,swaps,last valid/ready
//  cfg       in   cfg_index 0 tolerance, 1 size_in_use                  cfg_we, no wait
//
// Load takes one beat per cycle. After the last element the sequencer runs the
// elimination from the matrix memory (one read port, registered data): a pivot
// candidate is read and compared; row-exchange elements are read and swapped;
// a multiplier uses the serial divider; a trailing update is read, multiplied,
// saturated and written; a result beat is read, captured and offered. Synchronous
// active-high reset; the matrix memory is not cleared. A stalled result holds the
// sequencer; no new element is taken until the last beat of a run has left.
module lu_decomposition_partial_pivot import ludpp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  ludpp_in_if.sink          in_ch,
  ludpp_out_if.source       out_ch,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [TOL_W-1:0]  cfg_wdata
);

  // config
  logic [TOL_W-1:0] tolerance;
  logic [DIM_W-1:0] size_in_use;
  logic [DIM_W-1:0] n;
  logic [IDX_W-1:0] nm1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance   <= TOL_W'(1);
      size_in_use <= DIM_W'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TOLERANCE: tolerance   <= cfg_wdata;
        REG_SIZE:      size_in_use <= cfg_wdata[DIM_W-1:0];
        default:       ;
      endcase
    end
  end

  // size 0 acts as 1, oversize clamps
  always_comb begin
    if (size_in_use == '0)                   n = DIM_W'(1);
    else if (size_in_use > DIM_W'(MAX_DIM))  n = DIM_W'(MAX_DIM);
    else                                     n = size_in_use;
  end
  assign nm1 = IDX_W'(n - DIM_W'(1));

  // matrix memory
  logic [DATA_W-1:0] mem [MAX_DIM*MAX_DIM];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [DATA_W-1:0] mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [DATA_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata <= mem[mem_raddr];
  end

  // sequencer state
  state_t state, state_next;
  logic [IDX_W-1:0] lr, lc;        // load position
  logic [IDX_W-1:0] i, j, k, c, r, brow;
  logic [DATA_W-1:0] best;
  logic [DATA_W-1:0] swa;
  logic [DATA_W-1:0] f;
  logic [DATA_W-1:0] piv;
  logic [DATA_W-1:0] aval;
  logic [DATA_W-1:0] mq;
  logic [2*DATA_W-1:0] prod;
  logic [DATA_W-1:0] rowbuf [MAX_DIM];
  logic [IDX_W-1:0]  perm [MAX_DIM];
  logic [CNT_W-1:0]  exch;

  // result register
  logic              o_success;
  logic [IDX_W-1:0]  o_row, o_col, o_perm;
  logic [DATA_W-1:0] o_value;
  logic [CNT_W-1:0]  o_swaps;
  logic              o_last;

  logic in_acc, out_acc, load_last, piv_fail;
  logic [DATA_W-1:0] rd_mag;
  logic div_start, div_done;
  logic [DATA_W-1:0] div_q;
  logic [63:0] prod_adj;
  logic [DATA_W:0] diff;

  assign in_acc    = in_ch.valid && in_ch.ready;
  assign out_acc   = out_ch.valid && out_ch.ready;
  assign load_last = (lr == nm1) && (lc == nm1);
  assign rd_mag    = mem_rdata[DATA_W-1] ? (~mem_rdata + 1'b1) : mem_rdata;
  assign piv_fail  = best < {1'b0, tolerance};

  // qmul: truncate toward zero, then saturate; difference saturates too
  assign prod_adj = prod + (prod[63] ? 64'd65535 : 64'd0);
  assign diff     = {aval[DATA_W-1], aval} - {mq[DATA_W-1], mq};

  ludpp_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .a     (mem_rdata),
    .b     (piv),
    .done  (div_done),
    .q     (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= S_LOAD;
    else     state <= state_next;
  end

  always_comb begin
    state_next  = state;
    mem_we      = 1'b0;
    mem_waddr   = {lr, lc};
    mem_wdata   = in_ch.element_value;
    mem_raddr   = {r, c};
    div_start   = 1'b0;
    in_ch.ready = 1'b0;
    unique case (state)
      S_LOAD: begin
        in_ch.ready = 1'b1;
        if (in_acc) begin
          mem_we = 1'b1;
          if (load_last) state_next = S_PIV_RD;
        end
      end
      S_PIV_RD: begin
        mem_raddr  = {k, i};
        state_next = S_PIV_CMP;
      end
      S_PIV_CMP: state_next = (k == nm1) ? S_PIV_CHK : S_PIV_RD;
      S_PIV_CHK: begin
        if (piv_fail)       state_next = S_O_WAIT;
        else if (brow != i) state_next = S_SW_RA;
        else                state_next = S_ROW_RD;
      end
      S_SW_RA: begin
        mem_raddr  = {i, c};
        state_next = S_SW_RB;
      end
      S_SW_RB: begin
        mem_raddr  = {brow, c};
        state_next = S_SW_WA;
      end
      S_SW_WA: begin
        mem_we     = 1'b1;
        mem_waddr  = {i, c};
        mem_wdata  = mem_rdata;
        state_next = S_SW_WB;
      end
      S_SW_WB: begin
        mem_we     = 1'b1;
        mem_waddr  = {brow, c};
        mem_wdata  = swa;
        state_next = (c == nm1) ? S_ROW_RD : S_SW_RA;
      end
      S_ROW_RD: begin
        mem_raddr  = {i, k};
        state_next = S_ROW_CAP;
      end
      S_ROW_CAP: begin
        if (k != nm1)      state_next = S_ROW_RD;
        else if (i == nm1) state_next = S_O_RD;
        else               state_next = S_F_RD;
      end
      S_F_RD: begin
        mem_raddr  = {j, i};
        state_next = S_F_DIV;
      end
      S_F_DIV: begin
        div_start  = 1'b1;
        state_next = S_F_WAIT;
      end
      S_F_WAIT: begin
        if (div_done) begin
          mem_we     = 1'b1;
          mem_waddr  = {j, i};
          mem_wdata  = div_q;
          state_next = S_E_RD;
        end
      end
      S_E_RD: begin
        mem_raddr  = {j, k};
        state_next = S_E_MUL;
      end
      S_E_MUL: state_next = S_E_SAT;
      S_E_SAT: state_next = S_E_WR;
      S_E_WR: begin
        mem_we    = 1'b1;
        mem_waddr = {j, k};
        mem_wdata = sat48({{(47-DATA_W){diff[DATA_W]}}, diff});
        if (k != nm1)      state_next = S_E_RD;
        else if (j != nm1) state_next = S_F_RD;
        else               state_next = S_PIV_RD;
      end
      S_O_RD: begin
        mem_raddr  = {r, c};
        state_next = S_O_CAP;
      end
      S_O_CAP: state_next = S_O_WAIT;
      S_O_WAIT: begin
        if (out_acc) state_next = o_last ? S_LOAD : S_O_RD;
      end
      default: state_next = S_LOAD;
    endcase
  end

  // datapath and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      lr   <= '0;
      lc   <= '0;
      exch <= '0;
      for (int p = 0; p < MAX_DIM; p++) perm[p] <= IDX_W'(p);
    end else begin
      if (cfg_we && cfg_index == REG_SIZE) begin
        lr <= '0;
        lc <= '0;
      end
      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            if (load_last) begin
              lr   <= '0;
              lc   <= '0;
              i    <= '0;
              k    <= '0;
              best <= '0;
              brow <= '0;
              exch <= '0;
              for (int p = 0; p < MAX_DIM; p++) perm[p] <= IDX_W'(p);
            end else if (lc == nm1) begin
              lc <= '0;
              lr <= lr + 1'b1;
            end else begin
              lc <= lc + 1'b1;
            end
          end
        end
        S_PIV_CMP: begin
          if (rd_mag > best) begin
            best <= rd_mag;
            brow <= k;
          end
          if (k != nm1) k <= k + 1'b1;
        end
        S_PIV_CHK: begin
          if (piv_fail) begin
            o_success <= 1'b0;
            o_row     <= '0;
            o_col     <= '0;
            o_value   <= '0;
            o_perm    <= '0;
            o_swaps   <= '0;
            o_last    <= 1'b1;
          end else if (brow != i) begin
            c          <= '0;
            perm[i]    <= perm[brow];
            perm[brow] <= perm[i];
            exch       <= exch + 1'b1;
          end else begin
            k <= i;
          end
        end
        S_SW_RB: swa <= mem_rdata;
        S_SW_WB: begin
          if (c == nm1) k <= i;
          else          c <= c + 1'b1;
        end
        S_ROW_CAP: begin
          rowbuf[k] <= mem_rdata;
          if (k == i) piv <= mem_rdata;
          if (k != nm1) begin
            k <= k + 1'b1;
          end else if (i == nm1) begin
            r <= '0;
            c <= '0;
          end else begin
            j <= i + 1'b1;
          end
        end
        S_F_WAIT: begin
          if (div_done) begin
            f <= div_q;
            k <= i + 1'b1;
          end
        end
        S_E_MUL: begin
          aval <= mem_rdata;
          prod <= 64'($signed(f) * $signed(rowbuf[k]));
        end
        S_E_SAT: mq <= sat48(prod_adj[63:16]);
        S_E_WR: begin
          if (k != nm1) begin
            k <= k + 1'b1;
          end else if (j != nm1) begin
            j <= j + 1'b1;
          end else begin
            // next column
            i    <= i + 1'b1;
            k    <= i + 1'b1;
            best <= '0;
            brow <= i + 1'b1;
          end
        end
        S_O_CAP: begin
          o_success <= 1'b1;
          o_row     <= r;
          o_col     <= c;
          o_value   <= mem_rdata;
          o_perm    <= perm[r];
          o_swaps   <= exch;
          o_last    <= (r == nm1) && (c == nm1);
        end
        S_O_WAIT: begin
          if (out_acc && !o_last) begin
            if (c == nm1) begin
              c <= '0;
              r <= r + 1'b1;
            end else begin
              c <= c + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_ch.valid           = (state == S_O_WAIT);
  assign out_ch.success         = o_success;
  assign out_ch.row_index       = o_row;
  assign out_ch.column_index    = o_col;
  assign out_ch.lu_value        = o_value;
  assign out_ch.permutation_row = o_perm;
  assign out_ch.swap_count      = o_swaps;
  assign out_ch.last_result     = o_last;

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_ch.valid && in_ch.ready))
    else $error("result beat offered while loading");

  a_fail_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.success) |-> out_ch.last_result)
    else $error("failure beat without last mark");

  a_div_done_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_F_WAIT))
    else $error("divider finished outside its wait state");

  a_last_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_acc && out_ch.last_result) |=> (state == S_LOAD))
    else $error("run did not return to load after last beat");

endmodule

// ===== rtl/ludpp_div.sv =====
// Radix-2 restoring divider for Q16.16: q = sat((a << 16) / b), truncated toward zero.
// Depends on ludpp_pkg.
module ludpp_div import ludpp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] a,
  input  logic [DATA_W-1:0] b,
  output logic              done,
  output logic [DATA_W-1:0] q
);

  localparam int NUM_W = DATA_W + 16;

  logic             busy;
  logic             fin;
  logic [5:0]       cnt;
  logic [NUM_W-1:0] num;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] den;
  logic             neg;
  logic             bzero;
  logic             azero;
  logic             aneg;
  logic [DATA_W:0]  trial;
  logic             fits;

  assign trial = {rem, num[NUM_W-1]};
  assign fits  = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      fin  <= 1'b0;
    end else begin
      fin <= 1'b0;
      if (start) begin
        neg   <= a[DATA_W-1] ^ b[DATA_W-1];
        aneg  <= a[DATA_W-1];
        azero <= (a == '0);
        bzero <= (b == '0);
        num   <= {(a[DATA_W-1] ? (~a + 1'b1) : a), 16'h0};
        den   <= b[DATA_W-1] ? (~b + 1'b1) : b;
        rem   <= '0;
        cnt   <= 6'(NUM_W);
        if (b == '0) fin  <= 1'b1;
        else         busy <= 1'b1;
      end else if (busy) begin
        rem <= fits ? DATA_W'(trial - {1'b0, den}) : trial[DATA_W-1:0];
        num <= {num[NUM_W-2:0], fits};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          fin  <= 1'b1;
        end
      end
    end
  end

  assign done = fin;

  always_comb begin
    if (bzero) begin
      if (azero)     q = '0;
      else if (aneg) q = 32'h8000_0000;
      else           q = 32'h7FFF_FFFF;
    end else if (neg) begin
      if (num > NUM_W'(33'h1_0000_0000 >> 1)) q = 32'h8000_0000;
      else                                     q = ~num[DATA_W-1:0] + 1'b1;
    end else begin
      if (|num[NUM_W-1:DATA_W-1]) q = 32'h7FFF_FFFF;
      else                        q = num[DATA_W-1:0];
    end
  end

endmodule
